// ===== design/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

   localparam int DEF_MAX_COLS = 128;
   localparam int DEF_MAX_ROWS = 32;

   localparam logic [0:0] CMD_PUT  = 1'b0;
   localparam logic [0:0] CMD_READ = 1'b1;

   localparam logic [0:0] CSR_COLS_IDX = 1'b0;
   localparam logic [0:0] CSR_ROWS_IDX = 1'b1;

   localparam logic [7:0] SPACE_CODE   = 8'h20;
   localparam logic [7:0] NEWLINE_CODE = 8'h0A;

   localparam logic [7:0] COLS_RESET = 8'd80;
   localparam logic [5:0] ROWS_RESET = 6'd25;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RDWAIT,
      ST_COPY,
      ST_DRAIN,
      ST_FILL,
      ST_EXEC,
      ST_NLFILL,
      ST_DONE
   } tcw_state_type;

endpackage

// ===== design/tcw_grid_ram.sv =====
// Character grid memory: one write port, one read port, registered read data.
module tcw_grid_ram #(
   parameter int DEPTH = tcw_pkg::DEF_MAX_COLS * tcw_pkg::DEF_MAX_ROWS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/text_console_writer_core.sv =====
// Text console writer: character grid with cursor, wrap, newline fill and scroll.
//
//  channel | direction | handshake                    | payload
//  req_    | in        | req_valid / req_stall        | cmd, char_code, read_row, read_col
//  rsp_    | out       | rsp_valid / rsp_stall        | read_data, cursor_row, cursor_col, scrolled
//  csr_    | in        | csr_valid / csr_ready (=1)   | csr_index, csr_wdata
//
// After reset the grid is cleared to spaces, one cell per cycle, with req_stall high. A read
// passes through RDWAIT to DONE; a put of a plain byte writes its cell in EXEC, and a newline
// fills the rest of the row with spaces in NLFILL. A scroll, when rows > 1, first copies rows
// 1 to rows-1 up by one row (COPY) and drains the last copy write (DRAIN), then blanks the
// last row (FILL), all through the single grid write port.
// One item is in flight at a time; the result register lets the next item be
// accepted while a result is stalled, but a finished item waits until it is free.
module text_console_writer_core #(
   parameter int MAX_COLS = tcw_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = tcw_pkg::DEF_MAX_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_cmd,
   input  logic [7:0] req_char_code,
   input  logic [4:0] req_read_row,
   input  logic [6:0] req_read_col,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic [5:0] rsp_cursor_row,
   output logic [6:0] rsp_cursor_col,
   output logic       rsp_scrolled,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_CW = ($clog2(MAX_COLS + 1) > 8) ? $clog2(MAX_COLS + 1) : 8;
   localparam int CNT_RW = ($clog2(MAX_ROWS + 2) > 6) ? $clog2(MAX_ROWS + 2) : 6;

   tcw_pkg::tcw_state_type state_ff, state_in;

   logic [7:0]        cfg_cols_ff, cfg_cols_in;
   logic [5:0]        cfg_rows_ff, cfg_rows_in;
   logic [CNT_RW-1:0] cur_row_ff, cur_row_in;
   logic [CNT_CW-1:0] cur_col_ff, cur_col_in;
   logic [CNT_RW-1:0] scan_row_ff, scan_row_in;
   logic [CNT_CW-1:0] scan_col_ff, scan_col_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [7:0]        char_ff, char_in;
   logic              scrolled_ff, scrolled_in;
   logic              in_range_ff, in_range_in;
   logic [7:0]        res_data_ff, res_data_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [AW-1:0]     wr_addr_ff, wr_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic [5:0]        rsp_row_ff, rsp_row_in;
   logic [6:0]        rsp_col_ff, rsp_col_in;
   logic              rsp_scr_ff, rsp_scr_in;

   logic [CNT_CW-1:0] eff_cols;
   logic [CNT_RW-1:0] eff_rows;
   logic [CNT_RW-1:0] p_row;
   logic [CNT_CW-1:0] p_col;
   logic              p_scroll;
   logic              req_take;
   logic              copy_last;
   logic              fill_last;
   logic              col_last;
   logic              rsp_free;
   logic              clr_last;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [7:0]        ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [7:0]        ram_rdata;

   function automatic logic [AW-1:0] cell_addr(input logic [CNT_RW-1:0] r,
                                               input logic [CNT_CW-1:0] c);
      return AW'(32'(r) * 32'(MAX_COLS) + 32'(c));
   endfunction

   tcw_grid_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // effective geometry
   always_comb begin
      if (cfg_cols_ff == 8'd0) begin
         eff_cols = CNT_CW'(1);
      end else if (CNT_CW'(cfg_cols_ff) > CNT_CW'(MAX_COLS)) begin
         eff_cols = CNT_CW'(MAX_COLS);
      end else begin
         eff_cols = CNT_CW'(cfg_cols_ff);
      end
      if (cfg_rows_ff == 6'd0) begin
         eff_rows = CNT_RW'(1);
      end else if (CNT_RW'(cfg_rows_ff) > CNT_RW'(MAX_ROWS)) begin
         eff_rows = CNT_RW'(MAX_ROWS);
      end else begin
         eff_rows = CNT_RW'(cfg_rows_ff);
      end
   end

   // cursor position at the start of a put
   always_comb begin
      p_row = cur_row_ff;
      p_col = cur_col_ff;
      if (cur_col_ff >= eff_cols) begin
         p_col = '0;
         p_row = cur_row_ff + CNT_RW'(1);
      end
      p_scroll = (p_row >= eff_rows);
      if (p_scroll) begin
         p_row = eff_rows - CNT_RW'(1);
      end
   end

   assign req_take  = (state_ff == tcw_pkg::ST_IDLE) && req_valid;
   assign copy_last = (scan_col_ff == eff_cols - CNT_CW'(1)) &&
                      (scan_row_ff + CNT_RW'(1) == eff_rows - CNT_RW'(1));
   assign fill_last = (scan_col_ff == eff_cols - CNT_CW'(1));
   assign col_last  = (cur_col_ff + CNT_CW'(1) >= eff_cols);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign clr_last  = (clr_addr_ff == AW'(DEPTH - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_cmd == tcw_pkg::CMD_READ) begin
                  state_in = tcw_pkg::ST_RDWAIT;
               end else if (!p_scroll) begin
                  state_in = tcw_pkg::ST_EXEC;
               end else if (eff_rows == CNT_RW'(1)) begin
                  state_in = tcw_pkg::ST_FILL;
               end else begin
                  state_in = tcw_pkg::ST_COPY;
               end
            end
         end
         tcw_pkg::ST_RDWAIT: state_in = tcw_pkg::ST_DONE;
         tcw_pkg::ST_COPY: begin
            if (copy_last) begin
               state_in = tcw_pkg::ST_DRAIN;
            end
         end
         tcw_pkg::ST_DRAIN: state_in = tcw_pkg::ST_FILL;
         tcw_pkg::ST_FILL: begin
            if (fill_last) begin
               state_in = tcw_pkg::ST_EXEC;
            end
         end
         tcw_pkg::ST_EXEC: begin
            if (char_ff == tcw_pkg::NEWLINE_CODE) begin
               state_in = tcw_pkg::ST_NLFILL;
            end else begin
               state_in = tcw_pkg::ST_DONE;
            end
         end
         tcw_pkg::ST_NLFILL: begin
            if (col_last) begin
               state_in = tcw_pkg::ST_DONE;
            end
         end
         tcw_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         default: state_in = tcw_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cfg_cols_in  = cfg_cols_ff;
      cfg_rows_in  = cfg_rows_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      scan_row_in  = scan_row_ff;
      scan_col_in  = scan_col_ff;
      clr_addr_in  = clr_addr_ff;
      char_in      = char_ff;
      scrolled_in  = scrolled_ff;
      in_range_in  = in_range_ff;
      res_data_in  = res_data_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_scr_in   = rsp_scr_ff;
      ram_we       = 1'b0;
      ram_waddr    = wr_addr_ff;
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = cell_addr(CNT_RW'(req_read_row), CNT_CW'(req_read_col));

      if (csr_valid) begin
         if (csr_index == tcw_pkg::CSR_COLS_IDX) begin
            cfg_cols_in = csr_wdata;
         end else begin
            cfg_rows_in = csr_wdata[5:0];
         end
      end

      case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = tcw_pkg::SPACE_CODE;
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         tcw_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_cmd == tcw_pkg::CMD_READ) begin
                  ram_re      = 1'b1;
                  in_range_in = (32'(req_read_row) < 32'(MAX_ROWS)) &&
                                (32'(req_read_col) < 32'(MAX_COLS));
                  scrolled_in = 1'b0;
               end else begin
                  cur_row_in  = p_row;
                  cur_col_in  = p_col;
                  char_in     = req_char_code;
                  scrolled_in = p_scroll;
                  res_data_in = 8'd0;
                  scan_row_in = '0;
                  scan_col_in = '0;
               end
            end
         end
         tcw_pkg::ST_RDWAIT: begin
            res_data_in = in_range_ff ? ram_rdata : 8'd0;
         end
         tcw_pkg::ST_COPY: begin
            ram_re     = 1'b1;
            ram_raddr  = cell_addr(scan_row_ff + CNT_RW'(1), scan_col_ff);
            wr_pend_in = 1'b1;
            wr_addr_in = cell_addr(scan_row_ff, scan_col_ff);
            if (fill_last) begin
               scan_col_in = '0;
               scan_row_in = scan_row_ff + CNT_RW'(1);
            end else begin
               scan_col_in = scan_col_ff + CNT_CW'(1);
            end
         end
         tcw_pkg::ST_DRAIN: begin
            scan_col_in = '0;
         end
         tcw_pkg::ST_FILL: begin
            ram_we      = 1'b1;
            ram_waddr   = cell_addr(eff_rows - CNT_RW'(1), scan_col_ff);
            ram_wdata   = tcw_pkg::SPACE_CODE;
            scan_col_in = scan_col_ff + CNT_CW'(1);
         end
         tcw_pkg::ST_EXEC: begin
            if (char_ff != tcw_pkg::NEWLINE_CODE) begin
               ram_we    = 1'b1;
               ram_waddr = cell_addr(cur_row_ff, cur_col_ff);
               ram_wdata = char_ff;
               if (col_last) begin
                  cur_col_in = '0;
                  cur_row_in = cur_row_ff + CNT_RW'(1);
               end else begin
                  cur_col_in = cur_col_ff + CNT_CW'(1);
               end
            end
         end
         tcw_pkg::ST_NLFILL: begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(cur_row_ff, cur_col_ff);
            ram_wdata = tcw_pkg::SPACE_CODE;
            if (col_last) begin
               cur_col_in = '0;
               cur_row_in = cur_row_ff + CNT_RW'(1);
            end else begin
               cur_col_in = cur_col_ff + CNT_CW'(1);
            end
         end
         tcw_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_row_in   = cur_row_ff[5:0];
               rsp_col_in   = cur_col_ff[6:0];
               rsp_scr_in   = scrolled_ff;
            end
         end
         default: begin
         end
      endcase

      // delayed write of a copied cell wins the port
      if (wr_pend_ff) begin
         ram_we    = 1'b1;
         ram_waddr = wr_addr_ff;
         ram_wdata = ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_CLEAR;
         cfg_cols_ff  <= tcw_pkg::COLS_RESET;
         cfg_rows_ff  <= tcw_pkg::ROWS_RESET;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         clr_addr_ff  <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_cols_ff  <= cfg_cols_in;
         cfg_rows_ff  <= cfg_rows_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         clr_addr_ff  <= clr_addr_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_row_ff <= scan_row_in;
      scan_col_ff <= scan_col_in;
      char_ff     <= char_in;
      scrolled_ff <= scrolled_in;
      in_range_ff <= in_range_in;
      res_data_ff <= res_data_in;
      wr_addr_ff  <= wr_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

   assign req_stall      = (state_ff != tcw_pkg::ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_scrolled   = rsp_scr_ff;

`ifndef SYNTHESIS
   a_wr_pend_from_copy: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> $past(state_ff == tcw_pkg::ST_COPY))
      else $error("copy write without a copy read");

   a_fill_port_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_FILL) |-> !wr_pend_ff)
      else $error("row fill collides with copy write");

   a_copy_in_rows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_COPY) |-> (scan_row_ff + CNT_RW'(1) < eff_rows))
      else $error("scroll copy beyond rows in use");

   a_done_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_DONE && rsp_free) |=> rsp_valid_ff)
      else $error("finished item not presented");
`endif

endmodule

// ===== tb/sv/text_console_writer_core_checker.sv =====
// Checker for the text console writer: mirrors the grid and cursor, compares every result.
module text_console_writer_core_checker #(
   parameter int MAX_COLS = tcw_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = tcw_pkg::DEF_MAX_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_cmd,
   input  logic [7:0] req_char_code,
   input  logic [4:0] req_read_row,
   input  logic [6:0] req_read_col,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_read_data,
   input  logic [5:0] rsp_cursor_row,
   input  logic [6:0] rsp_cursor_col,
   input  logic       rsp_scrolled,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   output int         mismatches,
   output int         reports_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] read_data;
      logic [5:0] cursor_row;
      logic [6:0] cursor_col;
      logic       scrolled;
   } console_report_type;

   logic [7:0] screen [MAX_ROWS][MAX_COLS];
   int unsigned cursor_row_q;
   int unsigned cursor_col_q;
   logic [7:0] cols_reg;
   logic [5:0] rows_reg;
   console_report_type cursor_reports_q [$];

   function automatic console_report_type console_step(logic cmd, logic [7:0] ch,
                                                        logic [4:0] rr, logic [6:0] rc);
      console_report_type rep;
      int cols;
      int rows;
      int row;
      int col;
      int r;
      int c;
      rep = '0;
      if (cmd == tcw_pkg::CMD_READ) begin
         if (rr < MAX_ROWS && rc < MAX_COLS)
            rep.read_data = screen[rr][rc];
      end else begin
         cols = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
         rows = (rows_reg == 0) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
         row = cursor_row_q;
         col = cursor_col_q;
         if (col >= cols) begin
            col = 0;
            row++;
         end
         if (row >= rows) begin
            for (r = 0; r + 1 < rows; r++)
               for (c = 0; c < cols; c++)
                  screen[r][c] = screen[r + 1][c];
            for (c = 0; c < cols; c++)
               screen[rows - 1][c] = tcw_pkg::SPACE_CODE;
            row = rows - 1;
            rep.scrolled = 1'b1;
         end
         if (ch == tcw_pkg::NEWLINE_CODE) begin
            while (col < cols) begin
               screen[row][col] = tcw_pkg::SPACE_CODE;
               col++;
            end
         end else begin
            screen[row][col] = ch;
            col++;
         end
         if (col >= cols) begin
            row++;
            col = 0;
         end
         cursor_row_q = row;
         cursor_col_q = col;
      end
      rep.cursor_row = cursor_row_q[5:0];
      rep.cursor_col = cursor_col_q[6:0];
      return rep;
   endfunction

   function automatic void check_field(string name, int unsigned expv, int unsigned actv);
      if (expv != actv) begin
         $error("%s: expected %0d, got %0d", name, expv, actv);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      console_report_type want;
      if (reset) begin
         for (int r = 0; r < MAX_ROWS; r++)
            for (int c = 0; c < MAX_COLS; c++)
               screen[r][c] = tcw_pkg::SPACE_CODE;
         cursor_row_q = 0;
         cursor_col_q = 0;
         cols_reg = tcw_pkg::COLS_RESET;
         rows_reg = tcw_pkg::ROWS_RESET;
         cursor_reports_q.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == tcw_pkg::CSR_COLS_IDX)
               cols_reg = csr_wdata;
            else
               rows_reg = csr_wdata[5:0];
         end
         if (req_valid && !req_stall)
            cursor_reports_q.push_back(console_step(req_cmd, req_char_code,
                                                    req_read_row, req_read_col));
         if (rsp_valid && !rsp_stall) begin
            if (cursor_reports_q.size() == 0) begin
               $error("result with no item waiting: read_data %0d cursor %0d,%0d",
                      rsp_read_data, rsp_cursor_row, rsp_cursor_col);
               mismatches++;
            end else begin
               want = cursor_reports_q.pop_front();
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("cursor_row", want.cursor_row, rsp_cursor_row);
               check_field("cursor_col", want.cursor_col, rsp_cursor_col);
               check_field("scrolled", want.scrolled, rsp_scrolled);
            end
         end
      end
      reports_pending <= cursor_reports_q.size();
   end

endmodule

// ===== tb/sv/text_console_writer_core_tb.sv =====
// Testbench top for the text console writer: stimulus, flow control, watchdog and verdict.
module text_console_writer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 50000;
   localparam int HOLD_CYCLES = 400;
   localparam int N_PHASES = 12;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_cmd = tcw_pkg::CMD_PUT;
   logic [7:0] req_char_code = 8'h00;
   logic [4:0] req_read_row = 5'd0;
   logic [6:0] req_read_col = 7'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_data;
   logic [5:0] rsp_cursor_row;
   logic [6:0] rsp_cursor_col;
   logic       rsp_scrolled;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = tcw_pkg::CSR_COLS_IDX;
   logic [7:0] csr_wdata = 8'h00;

   int mismatches;
   int reports_pending;
   int quiet_cycles = 0;
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int hold_asks = 0;
   int hold_served = 0;
   logic [7:0] cols_now = tcw_pkg::COLS_RESET;
   logic [5:0] rows_now = tcw_pkg::ROWS_RESET;

   text_console_writer_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_char_code(req_char_code), .req_read_row(req_read_row),
      .req_read_col(req_read_col),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_read_data(rsp_read_data),
      .rsp_cursor_row(rsp_cursor_row), .rsp_cursor_col(rsp_cursor_col),
      .rsp_scrolled(rsp_scrolled),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   text_console_writer_core_checker console_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_char_code(req_char_code), .req_read_row(req_read_row),
      .req_read_col(req_read_col),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_read_data(rsp_read_data),
      .rsp_cursor_row(rsp_cursor_row), .rsp_cursor_col(rsp_cursor_col),
      .rsp_scrolled(rsp_scrolled),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatches(mismatches), .reports_pending(reports_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL text_console_writer_core");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
   end

   task automatic offer_item(logic cmd, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < snd_idle_pct && gap < 40)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_char_code <= ch;
      req_read_row <= rr;
      req_read_col <= rc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic offer_random_item();
      int er;
      int ec;
      logic [7:0] ch;
      er = (rows_now == 0) ? 1 :
           (rows_now > tcw_pkg::DEF_MAX_ROWS) ? tcw_pkg::DEF_MAX_ROWS : rows_now;
      ec = (cols_now == 0) ? 1 :
           (cols_now > tcw_pkg::DEF_MAX_COLS) ? tcw_pkg::DEF_MAX_COLS : cols_now;
      if ($urandom_range(0, 99) < 30) begin
         if ($urandom_range(0, 99) < 70)
            offer_item(tcw_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                       5'($urandom_range(0, er - 1)), 7'($urandom_range(0, ec - 1)));
         else
            offer_item(tcw_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                       5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
      end else begin
         ch = ($urandom_range(0, 99) < 15) ? tcw_pkg::NEWLINE_CODE :
                                             8'($urandom_range(0, 255));
         offer_item(tcw_pkg::CMD_PUT, ch, 5'($urandom_range(0, 31)),
                    7'($urandom_range(0, 127)));
      end
   endtask

   task automatic wait_console_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_geometry(logic [7:0] cols, logic [7:0] rows);
      csr_valid <= 1'b1;
      csr_index <= tcw_pkg::CSR_COLS_IDX;
      csr_wdata <= cols;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= tcw_pkg::CSR_ROWS_IDX;
      csr_wdata <= rows;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cols_now = cols;
      rows_now = rows[5:0];
   endtask

   initial begin
      logic [7:0] phase_cols [N_PHASES];
      logic [7:0] phase_rows [N_PHASES];
      int n_items;
      phase_cols = '{8'd0, 8'd1, 8'd128, 8'd255, 8'd128, 8'd4,
                     8'd80, 8'd7, 8'd0, 8'd0, 8'd0, 8'd0};
      phase_rows = '{8'd0, 8'd1, 8'd32, 8'd255, 8'd2, 8'd32,
                     8'd25, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset geometry, extremes of the fields
      offer_item(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
      offer_item(tcw_pkg::CMD_READ, 8'hFF, 5'd31, 7'd127);
      offer_item(tcw_pkg::CMD_PUT, 8'h00, 5'd0, 7'd0);
      offer_item(tcw_pkg::CMD_PUT, 8'hFF, 5'd31, 7'd127);
      offer_item(tcw_pkg::CMD_PUT, 8'h41, 5'd0, 7'd0);
      offer_item(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
      offer_item(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd2);
      offer_item(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CODE, 5'd0, 7'd0);
      offer_item(tcw_pkg::CMD_PUT, 8'h7E, 5'd0, 7'd0);
      offer_item(tcw_pkg::CMD_PUT, 8'h42, 5'd0, 7'd0);
      offer_item(tcw_pkg::CMD_PUT, 8'h43, 5'd0, 7'd0);
      wait_console_idle();
      // shrink below the cursor: wrap and scroll on the next put
      set_geometry(8'd2, 8'd1);
      offer_item(tcw_pkg::CMD_PUT, 8'h78, 5'd0, 7'd0);
      offer_item(tcw_pkg::CMD_PUT, 8'h79, 5'd0, 7'd0);
      offer_item(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
      offer_item(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd1);
      offer_item(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CODE, 5'd0, 7'd0);
      offer_item(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
      offer_item(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd2);
      offer_item(tcw_pkg::CMD_READ, 8'h00, 5'd1, 7'd0);
      wait_console_idle();

      for (int p = 0; p < N_PHASES; p++) begin
         if (p >= 8)
            set_geometry(8'($urandom_range(1, 24)), 8'($urandom_range(1, 10)));
         else
            set_geometry(phase_cols[p], phase_rows[p]);
         case (p % 4)
            0: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
            1: begin snd_idle_pct = 59; rcv_idle_pct = 0;  end
            2: begin snd_idle_pct = 0;  rcv_idle_pct = 59; end
            default: begin snd_idle_pct = 14; rcv_idle_pct = 14; end
         endcase
         n_items = (p == 2 || p == 3) ? 60 : 100;
         for (int i = 0; i < n_items; i++) begin
            if (p == 4 && i == 20)
               hold_asks++;
            offer_random_item();
         end
         wait_console_idle();
      end

      if (mismatches == 0 && reports_pending == 0)
         $display("PASS text_console_writer_core");
      else
         $display("FAIL text_console_writer_core");
      $finish;
   end

endmodule

// ===== sim.f =====
design/tcw_pkg.sv
design/tcw_grid_ram.sv
design/text_console_writer_core.sv
tb/sv/text_console_writer_core_checker.sv
tb/sv/text_console_writer_core_tb.sv
